[design/sups_pkg.sv]
// ----------------------------------------------------------------------------
// sups_pkg
// Shared codes for the stand-up pose sequencer: input modes, status codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
package sups_pkg;

    // input item modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_NOTICE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_WAIT = 2'd0;
    localparam logic [1:0] STAT_RUN  = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    // configuration register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_CROUCH = 3'd0;
    localparam logic [2:0] REG_TARGET = 3'd1;
    localparam logic [2:0] REG_DELAY  = 3'd2;
    localparam logic [2:0] REG_CROUCH_T = 3'd3;
    localparam logic [2:0] REG_HOLD   = 3'd4;
    localparam logic [2:0] REG_RAMP   = 3'd5;
    localparam logic [2:0] REG_EXIT   = 3'd6;
    localparam logic [2:0] REG_GAINS  = 3'd7;

    localparam int POSE_W = 48;

endpackage

[design/sups_lerp.sv]
// ----------------------------------------------------------------------------
// sups_lerp
// Shared interpolation unit: q = a + round((b - a) * t / d), magnitude
// rounded half away from zero. A multiply state, then one quotient bit
// per cycle by restoring division.
// ----------------------------------------------------------------------------
module sups_lerp
    import sups_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int TICK_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [POS_BITS-1:0]  a,
    input  logic signed [POS_BITS-1:0]  b,
    input  logic [TICK_BITS-1:0]        t,
    input  logic [TICK_BITS-1:0]        d,
    output logic                        done,
    output logic signed [POS_BITS-1:0]  q
);

    localparam int QW = POS_BITS + 1;
    localparam int PW = QW + TICK_BITS;
    localparam int NW = POS_BITS + TICK_BITS + 3;
    localparam int KW = $clog2(QW);

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} lst_t;

    lst_t                       st_reg;
    logic signed [POS_BITS-1:0] a_reg;
    logic                       neg_reg;
    logic [QW-1:0]              mag_reg;
    logic [TICK_BITS-1:0]       t_reg;
    logic [TICK_BITS-1:0]       d_reg;
    logic [NW-1:0]              rem_reg;
    logic [QW-1:0]              quo_reg;
    logic [KW-1:0]              k_reg;
    logic                       done_reg;
    logic signed [POS_BITS-1:0] q_reg;

    logic signed [QW-1:0] diff;
    logic [QW-1:0]        mag;
    logic [PW-1:0]        prod;
    logic [NW-1:0]        trial;
    logic                 fits;
    logic [QW-1:0]        quo_n;
    logic signed [QW:0]   sum;

    // difference and its magnitude
    assign diff = $signed({b[POS_BITS-1], b}) - $signed({a[POS_BITS-1], a});
    assign mag  = diff[QW-1] ? QW'(-diff) : diff;

    // multiply and divide step
    assign prod  = PW'(mag_reg) * PW'(t_reg);
    assign trial = NW'({d_reg, 1'b0}) << k_reg;
    assign fits  = rem_reg >= trial;

    always_comb
    begin
        quo_n = quo_reg;
        quo_n[k_reg] = fits;
    end

    assign sum = neg_reg ? ($signed({a_reg[POS_BITS-1], a_reg[POS_BITS-1], a_reg})
                            - $signed({1'b0, quo_n}))
                         : ($signed({a_reg[POS_BITS-1], a_reg[POS_BITS-1], a_reg})
                            + $signed({1'b0, quo_n}));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= L_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        a_reg   <= a;
                        neg_reg <= diff[QW-1];
                        mag_reg <= mag;
                        t_reg   <= t;
                        d_reg   <= d;
                        st_reg  <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    rem_reg <= NW'({prod, 1'b0}) + NW'(d_reg);
                    quo_reg <= '0;
                    k_reg   <= KW'(QW - 1);
                    st_reg  <= L_DIV;
                end
                L_DIV:
                begin
                    if (fits)
                        rem_reg <= rem_reg - trial;
                    quo_reg <= quo_n;
                    if (k_reg == '0)
                    begin
                        q_reg    <= POS_BITS'(sum);
                        done_reg <= 1'b1;
                        st_reg   <= L_IDLE;
                    end
                    else
                        k_reg <= k_reg - 1'b1;
                end
                default: st_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[design/stand_up_pose_sequencer.sv]
// ----------------------------------------------------------------------------
// stand_up_pose_sequencer
// Stand-up pose sequencer: captures the start pose, then per tick emits one
// position command per joint (interpolated in crouch and ramp; hold, stand).
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_ready  | mode, joint, measured_pos
//  out      | out_valid/out_ready| joint_out, position_cmd, has_command,
//           |                    | status, stop, last
//  config   | APB psel/penable   | paddr (8 * index), pwdata, prdata
//
//  A sample item is written while idle. In the crouch and ramp phases a tick
//  runs each joint through the shared lerp unit (a multiply state, then the
//  divide steps); the first tick adds a copy of the latest pose into the
//  start pose memory.
//  Reset clears the state, progress flags, counters and pose valid bits; no clearing pass is needed.
//  A stalled output holds the sequencer in place; in_ready is high only idle.
// ----------------------------------------------------------------------------
module stand_up_pose_sequencer
    import sups_pkg::*;
#(
    parameter int NUM_JOINTS = 12,
    parameter int POS_BITS   = 16,
    parameter int TICK_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [3:0]                 joint,
    input  logic signed [POS_BITS-1:0] measured_pos,
    // output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 joint_out,
    output logic signed [POS_BITS-1:0] position_cmd,
    output logic                       has_command,
    output logic [1:0]                 status,
    output logic                       stop,
    output logic                       last,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [5:0]                 paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int CW = $clog2(NUM_JOINTS + 1);
    localparam int EW = TICK_BITS + 2;
    localparam int DW = TICK_BITS + 1;
    localparam int WW = 3 * POS_BITS + POSE_W;
    localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};
    localparam logic [DW-1:0] DONE_MAX    = {DW{1'b1}};
    localparam logic [4:0]    NJ          = 5'(NUM_JOINTS);

    typedef enum logic [2:0] {
        S_IDLE, S_COPY, S_EVAL, S_EMIT, S_JRD, S_JCALC, S_JWAIT, S_JOUT
    } state_t;

    typedef enum logic [1:0] {P_CROUCH, P_HOLD, P_RAMP, P_STAND} phase_t;

    // configuration registers
    logic [POSE_W-1:0]    crouch_reg, target_reg;
    logic [TICK_BITS-1:0] delay_reg, crouch_t_reg, hold_reg, ramp_reg, exit_reg;
    logic [31:0]          gains_reg;

    // control state
    state_t               state_reg;
    phase_t               phase_reg;
    logic                 have_reg, started_reg, finished_reg, ctrl_up_reg, stopped_reg;
    logic [EW-1:0]        elapsed_reg;
    logic [DW-1:0]        done_reg;
    logic [NUM_JOINTS-1:0] lat_vld_reg;
    logic [CW-1:0]        cp_cnt_reg;
    logic [JW-1:0]        jidx_reg;
    logic [1:0]           lane_reg;
    logic [TICK_BITS-1:0] tl_reg, dv_reg;
    logic [1:0]           cmd_stat_reg, pend_stat_reg;
    logic                 pend_stop_reg;
    logic signed [POS_BITS-1:0] q_reg;

    // output register
    logic                 out_valid_reg;
    logic [3:0]           joint_out_reg;
    logic signed [POS_BITS-1:0] pos_reg;
    logic                 hc_reg, stop_reg, last_reg;
    logic [1:0]           stat_reg;

    // memories
    logic signed [POS_BITS-1:0] lat_mem [NUM_JOINTS];
    logic signed [POS_BITS-1:0] st_mem  [NUM_JOINTS];
    logic signed [POS_BITS-1:0] lat_rd_reg, st_rd_reg;
    logic                       lat_rdv_reg;

    logic                 accept, cfg_wr, slot_free, smp_wr, joint_ok, out_load;
    logic [JW-1:0]        lat_raddr, st_waddr;
    logic [1:0]           cur_stat;
    logic [TICK_BITS-1:0] cd, rd;
    logic [DW-1:0]        h_end;
    logic [EW-1:0]        s_end, t_full, t_ramp;
    logic                 in_delay, fin_n, exit_hit;
    logic [DW-1:0]        done_n;
    logic [WW-1:0]        cr_wide, tg_wide;
    logic signed [POS_BITS-1:0] cr_f, tg_f, la, lb;
    logic                 lrp_start, lrp_done;
    logic signed [POS_BITS-1:0] lrp_q;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign joint_ok  = {1'b0, joint} < NJ;
    assign smp_wr    = accept && !stopped_reg && (mode == MODE_SAMPLE) && joint_ok;
    assign cur_stat  = !started_reg ? STAT_WAIT : (finished_reg ? STAT_DONE : STAT_RUN);
    assign out_load  = (state_reg == S_EMIT || state_reg == S_JOUT) && slot_free;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crouch_reg   <= 48'd234857766780928;
            target_reg   <= 48'd249808424402944;
            delay_reg    <= TICK_BITS'(250);
            crouch_t_reg <= TICK_BITS'(500);
            hold_reg     <= TICK_BITS'(100);
            ramp_reg     <= TICK_BITS'(1000);
            exit_reg     <= TICK_BITS'(1000);
            gains_reg    <= 32'd83901440;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_CROUCH:   crouch_reg   <= pwdata[POSE_W-1:0];
                REG_TARGET:   target_reg   <= pwdata[POSE_W-1:0];
                REG_DELAY:    delay_reg    <= pwdata[TICK_BITS-1:0];
                REG_CROUCH_T: crouch_t_reg <= pwdata[TICK_BITS-1:0];
                REG_HOLD:     hold_reg     <= pwdata[TICK_BITS-1:0];
                REG_RAMP:     ramp_reg     <= pwdata[TICK_BITS-1:0];
                REG_EXIT:     exit_reg     <= pwdata[TICK_BITS-1:0];
                REG_GAINS:    gains_reg    <= pwdata[31:0];
                default:      ;
            endcase
        end
    end

    // configuration read
    always_comb
    begin
        unique case (paddr[5:3])
            REG_CROUCH:   prdata = 64'(crouch_reg);
            REG_TARGET:   prdata = 64'(target_reg);
            REG_DELAY:    prdata = 64'(delay_reg);
            REG_CROUCH_T: prdata = 64'(crouch_t_reg);
            REG_HOLD:     prdata = 64'(hold_reg);
            REG_RAMP:     prdata = 64'(ramp_reg);
            REG_EXIT:     prdata = 64'(exit_reg);
            REG_GAINS:    prdata = 64'(gains_reg);
            default:      prdata = '0;
        endcase
    end

    // latest pose memory: written by samples, read by the copy sweep
    assign lat_raddr = (cp_cnt_reg < CW'(NUM_JOINTS)) ? cp_cnt_reg[JW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (smp_wr)
            lat_mem[joint[JW-1:0]] <= measured_pos;
        lat_rd_reg  <= lat_mem[lat_raddr];
        lat_rdv_reg <= lat_vld_reg[lat_raddr];
    end

    // start pose memory: written by the copy sweep, read per joint
    assign st_waddr = JW'(cp_cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_COPY && cp_cnt_reg != '0)
            st_mem[st_waddr] <= lat_rdv_reg ? lat_rd_reg : '0;
        st_rd_reg <= st_mem[jidx_reg];
    end

    // phase boundaries
    assign cd       = (crouch_t_reg == '0) ? TICK_BITS'(1) : crouch_t_reg;
    assign rd       = (ramp_reg == '0) ? TICK_BITS'(1) : ramp_reg;
    assign h_end    = DW'(cd) + DW'(hold_reg);
    assign s_end    = EW'(h_end) + EW'(rd);
    assign in_delay = elapsed_reg < EW'(delay_reg);
    assign t_full   = elapsed_reg - EW'(delay_reg);
    assign t_ramp   = t_full - EW'(h_end);
    assign fin_n    = finished_reg || (t_full >= s_end);
    assign done_n   = (!finished_reg && fin_n) ? '0 : done_reg;
    assign exit_hit = fin_n && !ctrl_up_reg && (done_n > DW'(exit_reg));

    // pose fields for the current lane
    assign cr_wide = WW'(crouch_reg);
    assign tg_wide = WW'(target_reg);

    always_comb
    begin
        case (lane_reg)
            2'd1:
            begin
                cr_f = cr_wide[2*POS_BITS-1:POS_BITS];
                tg_f = tg_wide[2*POS_BITS-1:POS_BITS];
            end
            2'd2:
            begin
                cr_f = cr_wide[3*POS_BITS-1:2*POS_BITS];
                tg_f = tg_wide[3*POS_BITS-1:2*POS_BITS];
            end
            default:
            begin
                cr_f = cr_wide[POS_BITS-1:0];
                tg_f = tg_wide[POS_BITS-1:0];
            end
        endcase
    end

    // interpolation operands
    assign la = (phase_reg == P_CROUCH) ? st_rd_reg : cr_f;
    assign lb = (phase_reg == P_CROUCH) ? cr_f : tg_f;
    assign lrp_start = (state_reg == S_JCALC) &&
                       (phase_reg == P_CROUCH || phase_reg == P_RAMP);

    sups_lerp #(
        .POS_BITS  (POS_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lrp_start),
        .a     (la),
        .b     (lb),
        .t     (tl_reg),
        .d     (dv_reg),
        .done  (lrp_done),
        .q     (lrp_q)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_reg      <= 1'b0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            ctrl_up_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            elapsed_reg   <= '0;
            done_reg      <= '0;
            lat_vld_reg   <= '0;
            cp_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output valid: load wins over a drain in the same cycle
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && !stopped_reg)
                    begin
                        case (mode)
                            MODE_SAMPLE:
                            begin
                                if (joint_ok)
                                begin
                                    lat_vld_reg[joint[JW-1:0]] <= 1'b1;
                                    have_reg <= 1'b1;
                                end
                            end
                            MODE_NOTICE:
                            begin
                                ctrl_up_reg   <= 1'b1;
                                stopped_reg   <= 1'b1;
                                pend_stat_reg <= cur_stat;
                                pend_stop_reg <= 1'b1;
                                state_reg     <= S_EMIT;
                            end
                            MODE_TICK:
                            begin
                                if (!have_reg)
                                begin
                                    pend_stat_reg <= STAT_WAIT;
                                    pend_stop_reg <= 1'b0;
                                    state_reg     <= S_EMIT;
                                end
                                else
                                begin
                                    if (!started_reg)
                                    begin
                                        elapsed_reg <= '0;
                                        started_reg <= 1'b1;
                                        cp_cnt_reg  <= '0;
                                        state_reg   <= S_COPY;
                                    end
                                    else
                                    begin
                                        if (elapsed_reg < ELAPSED_MAX)
                                            elapsed_reg <= elapsed_reg + 1'b1;
                                        state_reg <= S_EVAL;
                                    end
                                    if (finished_reg && done_reg < DONE_MAX)
                                        done_reg <= done_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_COPY:
                begin
                    if (cp_cnt_reg == CW'(NUM_JOINTS))
                        state_reg <= S_EVAL;
                    else
                        cp_cnt_reg <= cp_cnt_reg + 1'b1;
                end
                S_EVAL:
                begin
                    if (in_delay)
                    begin
                        pend_stat_reg <= cur_stat;
                        pend_stop_reg <= 1'b0;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        finished_reg <= fin_n;
                        done_reg     <= done_n;
                        if (exit_hit)
                        begin
                            stopped_reg   <= 1'b1;
                            pend_stat_reg <= STAT_DONE;
                            pend_stop_reg <= 1'b1;
                            state_reg     <= S_EMIT;
                        end
                        else
                        begin
                            cmd_stat_reg <= fin_n ? STAT_DONE : STAT_RUN;
                            if (t_full < EW'(cd))
                            begin
                                phase_reg <= P_CROUCH;
                                tl_reg    <= t_full[TICK_BITS-1:0];
                                dv_reg    <= cd;
                            end
                            else if (t_full < EW'(h_end))
                                phase_reg <= P_HOLD;
                            else if (t_full < s_end)
                            begin
                                phase_reg <= P_RAMP;
                                tl_reg    <= t_ramp[TICK_BITS-1:0];
                                dv_reg    <= rd;
                            end
                            else
                                phase_reg <= P_STAND;
                            jidx_reg  <= '0;
                            lane_reg  <= 2'd0;
                            state_reg <= S_JRD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        joint_out_reg <= '0;
                        pos_reg       <= '0;
                        hc_reg        <= 1'b0;
                        stat_reg      <= pend_stat_reg;
                        stop_reg      <= pend_stop_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_JRD:
                    state_reg <= S_JCALC;
                S_JCALC:
                begin
                    if (lrp_start)
                        state_reg <= S_JWAIT;
                    else
                    begin
                        q_reg     <= (phase_reg == P_HOLD) ? cr_f : tg_f;
                        state_reg <= S_JOUT;
                    end
                end
                S_JWAIT:
                begin
                    if (lrp_done)
                    begin
                        q_reg     <= lrp_q;
                        state_reg <= S_JOUT;
                    end
                end
                S_JOUT:
                begin
                    if (slot_free)
                    begin
                        joint_out_reg <= 4'(jidx_reg);
                        pos_reg       <= q_reg;
                        hc_reg        <= 1'b1;
                        stat_reg      <= cmd_stat_reg;
                        stop_reg      <= 1'b0;
                        last_reg      <= (jidx_reg == JW'(NUM_JOINTS - 1));
                        if (jidx_reg == JW'(NUM_JOINTS - 1))
                            state_reg <= S_IDLE;
                        else
                        begin
                            jidx_reg  <= jidx_reg + 1'b1;
                            lane_reg  <= (lane_reg == 2'd2) ? 2'd0 : lane_reg + 1'b1;
                            state_reg <= S_JRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign joint_out    = joint_out_reg;
    assign position_cmd = pos_reg;
    assign has_command  = hc_reg;
    assign status       = stat_reg;
    assign stop         = stop_reg;
    assign last         = last_reg;

endmodule
